[rtl/core/fenc_pkg.sv]
// constants, slot codes and crc-16/arc byte update for the frame encoder
// no dependencies

package fenc_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 16;
  localparam int unsigned LimitW  = 17;
  localparam int unsigned CrcW    = 16;
  localparam int unsigned SlotN   = 8;
  localparam int unsigned SlotW   = $clog2(SlotN);

  localparam logic [ByteW-1:0]  SyncFirst     = 8'h54;
  localparam logic [ByteW-1:0]  SyncSecond    = 8'h47;
  localparam logic [LimitW-1:0] FrameOverhead = 17'd6;
  localparam logic [LimitW-1:0] LimitReset    = 17'd65541;
  localparam logic [CrcW-1:0]   CrcPoly       = 16'hA001;

  // result slots of one input item, emitted from lowest to highest
  localparam logic [SlotW-1:0] SlotSync0   = 3'd0;
  localparam logic [SlotW-1:0] SlotSync1   = 3'd1;
  localparam logic [SlotW-1:0] SlotLenHi   = 3'd2;
  localparam logic [SlotW-1:0] SlotLenLo   = 3'd3;
  localparam logic [SlotW-1:0] SlotData    = 3'd4;
  localparam logic [SlotW-1:0] SlotCrcHi   = 3'd5;
  localparam logic [SlotW-1:0] SlotCrcLo   = 3'd6;
  localparam logic [SlotW-1:0] SlotReject  = 3'd7;

  function automatic logic [CrcW-1:0] crc_feed(input logic [CrcW-1:0] crc,
                                               input logic [ByteW-1:0] b);
    logic [CrcW-1:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

[rtl/core/frame_encoder_crc16_core.sv]
// length-prefixed frame encoder with crc-16/arc trailer
// an item's results are held in mask_q, then registered one by one at the output
// throughput: one result per cycle unless m_axis_tready stalls; payload bytes
//   stream at one per cycle and headers/trailers stall input
// reset: asynchronous active low; clears frame state, crc, queue and output valid,
//   and sets buffer_limit to 65541
// depends on fenc_pkg

module frame_encoder_crc16_core
  import fenc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [LimitW-1:0] cfg_wdata_i,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [23:0]       s_axis_tdata,   // data_byte, payload_length
  input  logic              s_axis_tlast,   // last_byte
  input  logic [1:0]        s_axis_tuser,   // first_byte, empty_frame
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [7:0]        m_axis_tdata,   // wire_byte
  output logic              m_axis_tlast,   // frame_end
  output logic [1:0]        m_axis_tuser    // run_end, rejected
);

  logic [LimitW-1:0] limit_q;
  logic [CrcW-1:0]   crc_acc_q, crc_acc_d;
  logic              in_frame_q, in_frame_d;
  logic              dropping_q, dropping_d;

  logic [SlotN-1:0]  mask_q, mask_d, mask_new;
  logic [LenW-1:0]   len_q;
  logic [ByteW-1:0]  data_q;
  logic [CrcW-1:0]   crc_out_q, crc_new;

  logic              out_valid_q;
  logic [ByteW-1:0]  out_byte_q;
  logic              out_run_end_q, out_frame_end_q, out_rej_q;

  logic [ByteW-1:0]  in_data;
  logic [LenW-1:0]   in_len, len_eff;
  logic              in_first, in_last, in_empty;
  logic              in_xfer, out_load;
  logic [CrcW-1:0]   crc_base;
  logic              too_long;

  logic [SlotW-1:0]  cur_slot;
  logic [SlotN-1:0]  mask_rem;
  logic              cur_last;
  logic [ByteW-1:0]  cur_byte;

  assign in_data  = s_axis_tdata[7:0];
  assign in_len   = s_axis_tdata[23:8];
  assign in_first = s_axis_tuser[0];
  assign in_empty = s_axis_tuser[1];
  assign in_last  = s_axis_tlast;

  // pending result selection
  always_comb begin
    cur_slot = '0;
    for (int i = SlotN - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        cur_slot = SlotW'(i);
      end
    end
  end

  assign mask_rem = mask_q & ~(SlotN'(1) << cur_slot);
  assign cur_last = (mask_rem == '0);
  assign out_load = (|mask_q) && (!out_valid_q || m_axis_tready);

  always_comb begin
    unique case (cur_slot)
      SlotSync0:  cur_byte = SyncFirst;
      SlotSync1:  cur_byte = SyncSecond;
      SlotLenHi:  cur_byte = len_q[15:8];
      SlotLenLo:  cur_byte = len_q[7:0];
      SlotData:   cur_byte = data_q;
      SlotCrcHi:  cur_byte = crc_out_q[15:8];
      SlotCrcLo:  cur_byte = crc_out_q[7:0];
      SlotReject: cur_byte = '0;
      default:    cur_byte = '0;
    endcase
  end

  assign s_axis_tready = !(|mask_q) || (out_load && cur_last);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // per-item plan and frame state update
  assign len_eff  = in_empty ? '0 : in_len;
  assign too_long = ({1'b0, len_eff} + FrameOverhead) > limit_q;
  assign crc_base = in_first ? '0 : crc_acc_q;
  assign crc_new  = in_empty ? crc_base : crc_feed(crc_base, in_data);

  always_comb begin
    mask_new   = '0;
    crc_acc_d  = crc_acc_q;
    in_frame_d = in_frame_q;
    dropping_d = dropping_q;
    if (in_first) begin
      if (too_long) begin
        if (in_empty || in_last) begin
          mask_new[SlotReject] = 1'b1;
          in_frame_d = 1'b0;
          dropping_d = 1'b0;
        end else begin
          in_frame_d = 1'b1;
          dropping_d = 1'b1;
        end
        crc_acc_d = '0;
      end else begin
        mask_new[SlotSync0] = 1'b1;
        mask_new[SlotSync1] = 1'b1;
        mask_new[SlotLenHi] = 1'b1;
        mask_new[SlotLenLo] = 1'b1;
        mask_new[SlotData]  = !in_empty;
        if (in_empty || in_last) begin
          mask_new[SlotCrcHi] = 1'b1;
          mask_new[SlotCrcLo] = 1'b1;
          crc_acc_d  = '0;
          in_frame_d = 1'b0;
        end else begin
          crc_acc_d  = crc_new;
          in_frame_d = 1'b1;
        end
        dropping_d = 1'b0;
      end
    end else if (in_frame_q) begin
      if (dropping_q) begin
        if (in_last) begin
          mask_new[SlotReject] = 1'b1;
          in_frame_d = 1'b0;
          dropping_d = 1'b0;
          crc_acc_d  = '0;
        end
      end else begin
        mask_new[SlotData] = !in_empty;
        if (in_last) begin
          mask_new[SlotCrcHi] = 1'b1;
          mask_new[SlotCrcLo] = 1'b1;
          crc_acc_d  = '0;
          in_frame_d = 1'b0;
        end else begin
          crc_acc_d = crc_new;
        end
      end
    end
  end

  always_comb begin
    mask_d = mask_q;
    if (out_load) begin
      mask_d = mask_rem;
    end
    if (in_xfer) begin
      mask_d = mask_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= LimitReset;
      crc_acc_q   <= '0;
      in_frame_q  <= 1'b0;
      dropping_q  <= 1'b0;
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (in_xfer) begin
        crc_acc_q  <= crc_acc_d;
        in_frame_q <= in_frame_d;
        dropping_q <= dropping_d;
      end
      mask_q <= mask_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      len_q     <= len_eff;
      data_q    <= in_data;
      crc_out_q <= crc_new;
    end
    if (out_load) begin
      out_byte_q      <= cur_byte;
      out_run_end_q   <= cur_last;
      out_frame_end_q <= (cur_slot == SlotCrcLo) || (cur_slot == SlotReject);
      out_rej_q       <= (cur_slot == SlotReject);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tlast  = out_frame_end_q;
  assign m_axis_tuser  = {out_rej_q, out_run_end_q};

  a_busy_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($countones(mask_q) > 1) |-> !s_axis_tready)
    else $error("input taken while several results pending");

  a_reject_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mask_q[SlotReject] |-> (mask_q[SlotCrcLo:SlotSync0] == '0))
    else $error("reject result mixed with frame bytes");

  a_drop_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dropping_q |-> in_frame_q)
    else $error("dropping outside a frame");

  a_reject_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_rej_q) |-> (out_frame_end_q && out_run_end_q && out_byte_q == '0))
    else $error("malformed reject result");

endmodule

[dv/tb_top.sv]
// self-checking testbench for frame_encoder_crc16_core: directed table, then random frames
// predicts wire bytes with its own crc-16/arc framing model and checks every output transfer
// depends on fenc_pkg and the frame_encoder_crc16_core rtl

module tb_top;
  import fenc_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainCycles = 4;

  typedef struct packed {
    logic [7:0]  data;
    logic [15:0] len;
    logic        first;
    logic        last;
    logic        empty;
  } pay_item_t;

  typedef struct packed {
    logic [7:0] wbyte;
    logic       run_end;
    logic       frame_end;
    logic       rejected;
  } wire_res_t;

  typedef enum logic [0:0] {RowItem, RowLimit} row_kind_e;
  typedef enum logic [1:0] {ChkPredict, ChkNone, ChkEmpty, ChkReject} chk_e;

  typedef struct packed {
    row_kind_e         kind;
    chk_e              chk;
    logic [7:0]        data;
    logic [15:0]       len;
    logic              first;
    logic              last;
    logic              empty;
    logic [LimitW-1:0] limit;
  } row_t;

  row_t dir_tab [25] = '{
    '{RowItem,  ChkNone,    8'h3c, 16'h1234, 1'b0, 1'b1, 1'b0, 17'd0},
    '{RowItem,  ChkEmpty,   8'hff, 16'hffff, 1'b1, 1'b1, 1'b1, 17'd0},
    '{RowItem,  ChkPredict, 8'hff, 16'h0001, 1'b1, 1'b1, 1'b0, 17'd0},
    '{RowItem,  ChkPredict, 8'h00, 16'hffff, 1'b1, 1'b0, 1'b0, 17'd0},
    '{RowItem,  ChkPredict, 8'hff, 16'h0000, 1'b0, 1'b0, 1'b0, 17'd0},
    '{RowItem,  ChkNone,    8'h77, 16'h0000, 1'b0, 1'b0, 1'b1, 17'd0},
    '{RowItem,  ChkPredict, 8'h00, 16'h0000, 1'b0, 1'b1, 1'b1, 17'd0},
    '{RowItem,  ChkNone,    8'h99, 16'h0000, 1'b0, 1'b1, 1'b0, 17'd0},
    '{RowItem,  ChkPredict, 8'ha5, 16'h0003, 1'b1, 1'b0, 1'b0, 17'd0},
    '{RowItem,  ChkPredict, 8'h5a, 16'h0002, 1'b1, 1'b0, 1'b0, 17'd0},
    '{RowItem,  ChkPredict, 8'h01, 16'h0000, 1'b0, 1'b1, 1'b0, 17'd0},
    '{RowLimit, ChkNone,    8'h00, 16'h0000, 1'b0, 1'b0, 1'b0, 17'd6},
    '{RowItem,  ChkReject,  8'h12, 16'h0001, 1'b1, 1'b1, 1'b0, 17'd0},
    '{RowItem,  ChkPredict, 8'h34, 16'h0000, 1'b1, 1'b0, 1'b0, 17'd0},
    '{RowItem,  ChkPredict, 8'h56, 16'h0000, 1'b0, 1'b1, 1'b0, 17'd0},
    '{RowItem,  ChkNone,    8'h00, 16'h0005, 1'b1, 1'b0, 1'b0, 17'd0},
    '{RowItem,  ChkNone,    8'h01, 16'h0000, 1'b0, 1'b0, 1'b0, 17'd0},
    '{RowItem,  ChkNone,    8'h02, 16'h0000, 1'b0, 1'b0, 1'b1, 17'd0},
    '{RowItem,  ChkReject,  8'h03, 16'h0000, 1'b0, 1'b1, 1'b0, 17'd0},
    '{RowItem,  ChkEmpty,   8'h00, 16'h0000, 1'b1, 1'b0, 1'b1, 17'd0},
    '{RowLimit, ChkNone,    8'h00, 16'h0000, 1'b0, 1'b0, 1'b0, 17'd0},
    '{RowItem,  ChkReject,  8'h00, 16'h0000, 1'b1, 1'b0, 1'b1, 17'd0},
    '{RowItem,  ChkReject,  8'h09, 16'h0000, 1'b1, 1'b1, 1'b0, 17'd0},
    '{RowLimit, ChkNone,    8'h00, 16'h0000, 1'b0, 1'b0, 1'b0, 17'd65541},
    '{RowItem,  ChkPredict, 8'h80, 16'hffff, 1'b1, 1'b1, 1'b0, 17'd0}
  };

  logic              clk_i;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [LimitW-1:0] cfg_wdata_i = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [23:0]       s_axis_tdata = '0;   // data_byte, payload_length
  logic              s_axis_tlast = 1'b0; // last_byte
  logic [1:0]        s_axis_tuser = '0;   // first_byte, empty_frame
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [7:0]        m_axis_tdata;        // wire_byte
  logic              m_axis_tlast;        // frame_end
  logic [1:0]        m_axis_tuser;        // run_end, rejected

  frame_encoder_crc16_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  // encoder model state
  logic [LimitW-1:0] buf_limit = LimitReset;
  logic [15:0]       crc_run = '0;
  logic              frame_open = 1'b0;
  logic              frame_drop = 1'b0;

  wire_res_t   item_bytes[$];
  wire_res_t   wire_bytes_due[$];
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("frame_encoder_crc16_core verification failed");
      $finish;
    end
  end

  function automatic logic [15:0] crc16_arc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
    end
    return r;
  endfunction

  function automatic void put_wire(input logic [7:0] b, input logic fend, input logic rej);
    item_bytes.push_back('{b, 1'b0, fend, rej});
  endfunction

  function automatic void close_crc();
    put_wire(crc_run[15:8], 1'b0, 1'b0);
    put_wire(crc_run[7:0], 1'b1, 1'b0);
    frame_open = 1'b0;
    frame_drop = 1'b0;
    crc_run = '0;
  endfunction

  function automatic void close_reject();
    put_wire(8'h00, 1'b1, 1'b1);
    frame_open = 1'b0;
    frame_drop = 1'b0;
    crc_run = '0;
  endfunction

  function automatic void encode_item(input pay_item_t it);
    logic [15:0] len;
    item_bytes.delete();
    if (it.first) begin
      len = it.empty ? 16'd0 : it.len;
      frame_open = 1'b1;
      crc_run = '0;
      frame_drop = ({1'b0, len} + FrameOverhead) > buf_limit;
      if (frame_drop) begin
        if (it.empty || it.last) close_reject();
      end else begin
        put_wire(SyncFirst, 1'b0, 1'b0);
        put_wire(SyncSecond, 1'b0, 1'b0);
        put_wire(len[15:8], 1'b0, 1'b0);
        put_wire(len[7:0], 1'b0, 1'b0);
        if (it.empty) begin
          close_crc();
        end else begin
          put_wire(it.data, 1'b0, 1'b0);
          crc_run = crc16_arc_byte(crc_run, it.data);
          if (it.last) close_crc();
        end
      end
    end else if (frame_open) begin
      if (frame_drop) begin
        if (it.last) close_reject();
      end else begin
        if (!it.empty) begin
          put_wire(it.data, 1'b0, 1'b0);
          crc_run = crc16_arc_byte(crc_run, it.data);
        end
        if (it.last) close_crc();
      end
    end
    if (item_bytes.size() > 0) item_bytes[item_bytes.size()-1].run_end = 1'b1;
  endfunction

  task automatic send_item(input pay_item_t it, input chk_e chk, input bit calm);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      @(negedge clk_i) s_axis_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tdata  = {it.len, it.data};
    s_axis_tlast  = it.last;
    s_axis_tuser  = {it.empty, it.first};
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    if (it.first || frame_open) items_sent++;
    encode_item(it);
    case (chk)
      ChkPredict: foreach (item_bytes[k]) wire_bytes_due.push_back(item_bytes[k]);
      ChkEmpty: begin
        wire_bytes_due.push_back('{SyncFirst, 1'b0, 1'b0, 1'b0});
        wire_bytes_due.push_back('{SyncSecond, 1'b0, 1'b0, 1'b0});
        repeat (3) wire_bytes_due.push_back('{8'h00, 1'b0, 1'b0, 1'b0});
        wire_bytes_due.push_back('{8'h00, 1'b1, 1'b1, 1'b0});
      end
      ChkReject: wire_bytes_due.push_back('{8'h00, 1'b1, 1'b1, 1'b1});
      default: ;
    endcase
  endtask

  // hold the input side until every expected transfer has left the block
  task automatic quiesce();
    @(negedge clk_i) s_axis_tvalid = 1'b0;
    while (wire_bytes_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [LimitW-1:0] v);
    quiesce();
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = v;
    @(posedge clk_i) buf_limit = v;
    @(negedge clk_i) cfg_we_i = 1'b0;
  endtask

  task automatic random_frame();
    pay_item_t it;
    pay_item_t hole;
    int        n;
    int        pick;
    int        mode;
    int        tail;
    bit        calm;
    calm = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 29) == 0) quiesce();
    pick     = $urandom_range(0, 99);
    it.data  = 8'($urandom);
    it.len   = 16'($urandom);
    it.last  = 1'($urandom);
    it.empty = 1'($urandom);
    if (pick < 8) begin
      it.first = 1'b0;
      send_item(it, ChkPredict, calm);
      return;
    end
    it.first = 1'b1;
    if (pick < 15) begin
      it.empty = 1'b1;
      send_item(it, ChkPredict, calm);
      return;
    end
    n    = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 24) : $urandom_range(1, 10);
    mode = $urandom_range(0, 9);
    if (mode < 5) it.len = 16'(n);
    else if (mode < 7) it.len = 16'($urandom_range(0, 63));
    else if (mode < 9) it.len = 16'($urandom);
    else it.len = 16'($urandom_range(65530, 65535));
    it.empty = 1'b0;
    for (int k = 0; k < n; k++) begin
      if (k > 0) begin
        it.first = 1'b0;
        it.len   = 16'($urandom);
        it.data  = 8'($urandom);
        if ($urandom_range(0, 9) == 0) begin
          hole = it;
          hole.empty = 1'b1;
          hole.last  = 1'b0;
          send_item(hole, ChkPredict, calm);
        end
      end
      it.last = 1'b0;
      tail = (k == n - 1) ? $urandom_range(0, 19) : 2;
      if (k == n - 1 && tail == 0) return;
      if (k == n - 1 && tail != 1) it.last = 1'b1;
      send_item(it, ChkPredict, calm);
      if (k == n - 1 && tail == 1) begin
        hole = it;
        hole.first = 1'b0;
        hole.empty = 1'b1;
        hole.last  = 1'b1;
        hole.data  = 8'($urandom);
        send_item(hole, ChkPredict, calm);
      end
    end
  endtask

  initial begin : rx_side
    wire_res_t   got;
    wire_res_t   want;
    int          stall;
    int unsigned n_rx;
    bit          rx_calm;
    n_rx    = 0;
    rx_calm = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (n_rx % 16 == 0) rx_calm = ($urandom_range(0, 2) == 0);
      stall = rx_calm ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        @(negedge clk_i) m_axis_tready = 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
      @(negedge clk_i) m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      n_rx++;
      got = '{m_axis_tdata, m_axis_tuser[0], m_axis_tlast, m_axis_tuser[1]};
      if (wire_bytes_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: unexpected transfer byte=%02h run_end=%b frame_end=%b rej=%b",
                   got.wbyte, got.run_end, got.frame_end, got.rejected);
      end else begin
        want = wire_bytes_due.pop_front();
        if (got.wbyte !== want.wbyte || got.run_end !== want.run_end ||
            got.frame_end !== want.frame_end || got.rejected !== want.rejected) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp byte=%02h run=%b fend=%b rej=%b, ",
                      "got byte=%02h run=%b fend=%b rej=%b"},
                     want.wbyte, want.run_end, want.frame_end, want.rejected,
                     got.wbyte, got.run_end, got.frame_end, got.rejected);
        end
      end
    end
  end

  initial begin : tx_side
    pay_item_t         it;
    logic [LimitW-1:0] lim;
    int unsigned       target;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    foreach (dir_tab[r]) begin
      if (dir_tab[r].kind == RowLimit) begin
        write_limit(dir_tab[r].limit);
      end else begin
        it = '{dir_tab[r].data, dir_tab[r].len, dir_tab[r].first,
               dir_tab[r].last, dir_tab[r].empty};
        send_item(it, dir_tab[r].chk, 1'b0);
      end
    end

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0:       lim = 17'd6;
        1:       lim = LimitW'($urandom_range(6, 40));
        2:       lim = LimitReset;
        3:       lim = LimitW'($urandom_range(0, 5));
        4:       lim = LimitW'($urandom_range(6, 65541));
        5:       lim = 17'h1ffff;
        default: lim = LimitW'($urandom_range(8, 30));
      endcase
      write_limit(lim);
      target = items_sent + 42;
      while (items_sent < target) random_frame();
    end

    quiesce();
    if (mismatches == 0 && wire_bytes_due.size() == 0) begin
      $display("frame_encoder_crc16_core verification clean");
    end else begin
      $display("frame_encoder_crc16_core verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/fenc_pkg.sv
rtl/core/frame_encoder_crc16_core.sv
dv/tb_top.sv
